// ===== hw/rtl/svpwm_pkg.sv =====
// ----------------------------------------------------------------------------
// svpwm_pkg: shared types, constants and functions for the SVPWM duty unit
// Payload structs, fixed-point constants, sector codes and the elaboration
// time sine point generator used to fill the sector sine table.
// ----------------------------------------------------------------------------
package svpwm_pkg;

    // defaults for the top-level parameters
    localparam int ANGLE_BITS_DEF       = 16;
    localparam int DUTY_BITS_DEF        = 16;
    localparam int SINE_TABLE_DEPTH_DEF = 256;

    // fixed-point widths (30 fractional bits, Q0.30 sine)
    localparam int SIN_W  = 30;   // sine sample, always below 1.0
    localparam int P_W    = 31;   // sqrt3 * sine, below 1.5
    localparam int VM_W   = 13;   // voltage magnitude, up to 4096
    localparam int MAG_W  = P_W + VM_W;
    localparam int Q_W    = 33;   // magnitude / 1024, bounded below 2^33
    localparam int QT_W   = 32;   // magnitude / 3072
    localparam int T_W    = QT_W + 1;
    localparam int PH_W   = 36;   // signed phase time

    localparam longint PI3_Q30 = 64'sd1124419809;
    localparam logic [P_W-1:0] SQRT3_Q30 = 31'd1859775393;
    // ceil(2^34 / 3): x / 3 == (x * DIV3_M) >> 34 for x below 2^33
    localparam logic [32:0] DIV3_M = 33'd5726623062;
    localparam int DIV3_SH = 34;
    localparam logic [PH_W-1:0] ONE_Q30 = 36'd1073741824;

    typedef enum logic [2:0] {
        SEC_0 = 3'd0,
        SEC_1 = 3'd1,
        SEC_2 = 3'd2,
        SEC_3 = 3'd3,
        SEC_4 = 3'd4,
        SEC_5 = 3'd5
    } sector_t;

    typedef struct packed {
        logic signed [12:0] q_volts;
        logic [15:0]        rotor_angle;
    } svpwm_in_t;

    typedef struct packed {
        logic [15:0] duty_a;
        logic [15:0] duty_b;
        logic [15:0] duty_c;
        logic [2:0]  sector;
    } svpwm_out_t;

    // stage enables handed to the sine lookup
    typedef struct packed {
        logic rd_en;   // table read stage
        logic ip_en;   // interpolation stage
    } sine_ctl_t;

    // sin(x) in Q0.30, Taylor series to x^13, every product truncated
    function automatic logic [SIN_W-1:0] sine_q30(input longint x);
        longint x2;
        longint term;
        longint sum;
        x2   = (x * x) >> 30;
        term = x;
        sum  = x;
        term = ((term * x2) >> 30) / 6;
        sum  = sum - term;
        term = ((term * x2) >> 30) / 20;
        sum  = sum + term;
        term = ((term * x2) >> 30) / 42;
        sum  = sum - term;
        term = ((term * x2) >> 30) / 72;
        sum  = sum + term;
        term = ((term * x2) >> 30) / 110;
        sum  = sum - term;
        term = ((term * x2) >> 30) / 156;
        sum  = sum + term;
        return SIN_W'(sum);
    endfunction

endpackage

// ===== hw/rtl/svpwm_sine_lookup.sv =====
// ----------------------------------------------------------------------------
// svpwm_sine_lookup: sector sine by table and linear interpolation
// Two register stages: table read of the bracketing points, then
// lo + (diff * r) >> ANGLE_BITS. The table spans 0..60 degrees.
// ----------------------------------------------------------------------------
module svpwm_sine_lookup #(
    parameter int ANGLE_BITS       = svpwm_pkg::ANGLE_BITS_DEF,
    parameter int SINE_TABLE_DEPTH = svpwm_pkg::SINE_TABLE_DEPTH_DEF
) (
    input  logic                                   clk,
    input  svpwm_pkg::sine_ctl_t                   ctl,
    input  logic [$clog2(SINE_TABLE_DEPTH+1)-1:0]  idx,
    input  logic [ANGLE_BITS-1:0]                  rem,
    input  logic                                   top,
    output logic [svpwm_pkg::SIN_W-1:0]            sine
);

    localparam int KW = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int SW = svpwm_pkg::SIN_W;

    logic [SW-1:0] sine_tab [0:SINE_TABLE_DEPTH];

    for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++)
    begin : g_tab
        localparam longint X = svpwm_pkg::PI3_Q30 * k / SINE_TABLE_DEPTH;
        assign sine_tab[k] = svpwm_pkg::sine_q30(X);
    end

    logic [KW-1:0]         hi_idx;
    logic [SW-1:0]         lo_val;
    logic [SW-1:0]         hi_val;
    logic [SW-1:0]         diff_next;
    logic [SW-1:0]         lo_reg;
    logic [SW-1:0]         diff_reg;
    logic [ANGLE_BITS-1:0] rem_reg;
    logic [SW+ANGLE_BITS-1:0] step_prod;
    logic [SW-1:0]         sine_next;
    logic [SW-1:0]         sine_reg;

    // at the far end of the sector the top point stands alone
    assign hi_idx    = top ? idx : idx + KW'(1);
    assign lo_val    = sine_tab[idx];
    assign hi_val    = sine_tab[hi_idx];
    assign diff_next = (hi_val > lo_val) ? (hi_val - lo_val) : '0;

    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            lo_reg   <= lo_val;
            diff_reg <= diff_next;
            rem_reg  <= rem;
        end
    end

    assign step_prod = (SW+ANGLE_BITS)'(diff_reg) * (SW+ANGLE_BITS)'(rem_reg);
    assign sine_next = lo_reg + step_prod[SW+ANGLE_BITS-1:ANGLE_BITS];

    always_ff @(posedge clk)
    begin
        if (ctl.ip_en)
        begin
            sine_reg <= sine_next;
        end
    end

    assign sine = sine_reg;

endmodule

// ===== hw/rtl/space_vector_pwm_duty_unit.sv =====
// ----------------------------------------------------------------------------
// space_vector_pwm_duty_unit: three-phase center-aligned SVPWM duty generator
// Takes a signed Q2.10 quadrature voltage and an electrical angle per beat and
// returns the A/B/C duties and the sector. Fully pipelined: one command per
// cycle while the result side is not stalled. The datapath has 12 stages
// (position decode, table index, two sine table stages, three multiplier
// stages, sign, t1 + t2, half zero time, the three-phase combine and the duty
// rounding). Stalls on the result side back up stage by stage, so empty stages
// keep taking commands. No state survives between commands and no clearing
// pass is run: the sine table is constant logic.
// ----------------------------------------------------------------------------
module space_vector_pwm_duty_unit #(
    parameter int ANGLE_BITS       = svpwm_pkg::ANGLE_BITS_DEF,
    parameter int DUTY_BITS        = svpwm_pkg::DUTY_BITS_DEF,
    parameter int SINE_TABLE_DEPTH = svpwm_pkg::SINE_TABLE_DEPTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cmd_valid,
    output logic                   cmd_ready,
    input  svpwm_pkg::svpwm_in_t   cmd,
    output logic                   duty_valid,
    input  logic                   duty_ready,
    output svpwm_pkg::svpwm_out_t  duty
);

    localparam int NST  = 12;
    localparam int A    = ANGLE_BITS;
    localparam int KW   = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int PKW  = A + KW;
    localparam int SW   = svpwm_pkg::SIN_W;
    localparam int PW   = svpwm_pkg::P_W;
    localparam int VW   = svpwm_pkg::VM_W;
    localparam int MW   = svpwm_pkg::MAG_W;
    localparam int QW   = svpwm_pkg::Q_W;
    localparam int QTW  = svpwm_pkg::QT_W;
    localparam int TW   = svpwm_pkg::T_W;
    localparam int HW   = svpwm_pkg::PH_W;
    localparam int RW   = 31 + DUTY_BITS;

    localparam logic [A-1:0]   QTR_TURN = {2'b01, {(A-2){1'b0}}};
    localparam logic [A:0]     FULL_POS = {1'b1, {A{1'b0}}};
    localparam logic [RW-1:0]  RND_HALF = RW'(1) << 29;
    localparam logic [DUTY_BITS-1:0] DUTY_MAX = '1;

    // ------------------------------------------------------------------
    // stage control
    // ------------------------------------------------------------------
    logic [NST-1:0] vld_reg;
    logic [NST-1:0] vld_next;
    logic [NST-1:0] en;

    always_comb
    begin
        en[NST-1] = !vld_reg[NST-1] || duty_ready;
        for (int i = NST - 2; i >= 0; i--)
        begin
            en[i] = !vld_reg[i] || en[i+1];
        end
    end

    always_comb
    begin
        vld_next = vld_reg;
        if (en[0])
        begin
            vld_next[0] = cmd_valid;
        end
        for (int i = 1; i < NST; i++)
        begin
            if (en[i])
            begin
                vld_next[i] = vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign cmd_ready  = en[0];
    assign duty_valid = vld_reg[NST-1];

    // ------------------------------------------------------------------
    // stage 0: quarter-turn advance, sector split, voltage magnitude
    // ------------------------------------------------------------------
    logic [A-1:0]    ang_raw;
    logic [A-1:0]    ang_adv;
    logic [A+2:0]    s6;
    logic [VW-1:0]   vmag_in;

    svpwm_pkg::sector_t sec_reg  [0:NST-1];
    logic               neg_reg  [0:6];
    logic [VW-1:0]      vmag_reg [0:4];
    logic [A-1:0]       frac_reg;

    assign ang_raw = A'(cmd.rotor_angle);
    assign ang_adv = ang_raw + QTR_TURN;
    assign s6      = {ang_adv, 2'b00} + {1'b0, ang_adv, 1'b0};
    assign vmag_in = cmd.q_volts[12] ? $unsigned(~cmd.q_volts) + VW'(1)
                                     : $unsigned(cmd.q_volts);

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            sec_reg[0]  <= svpwm_pkg::sector_t'(s6[A+2:A]);
            neg_reg[0]  <= cmd.q_volts[12];
            vmag_reg[0] <= vmag_in;
            frac_reg    <= s6[A-1:0];
        end
        for (int i = 1; i < NST; i++)
        begin
            if (en[i])
            begin
                sec_reg[i] <= sec_reg[i-1];
            end
        end
        for (int i = 1; i < 7; i++)
        begin
            if (en[i])
            begin
                neg_reg[i] <= neg_reg[i-1];
            end
        end
        for (int i = 1; i < 5; i++)
        begin
            if (en[i])
            begin
                vmag_reg[i] <= vmag_reg[i-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 1: table index and remainder for both sector positions
    // ------------------------------------------------------------------
    logic [A:0]      pos1;
    logic [PKW-1:0]  pk1;
    logic [PKW-1:0]  pk2;
    logic [KW-1:0]   k1_reg;
    logic [KW-1:0]   k2_reg;
    logic [A-1:0]    r1_reg;
    logic [A-1:0]    r2_reg;
    logic            top1_reg;
    logic            top2_reg;

    assign pos1 = FULL_POS - {1'b0, frac_reg};
    assign pk1  = PKW'(pos1) * PKW'(SINE_TABLE_DEPTH);
    assign pk2  = PKW'(frac_reg) * PKW'(SINE_TABLE_DEPTH);

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            k1_reg   <= pk1[PKW-1:A];
            r1_reg   <= pk1[A-1:0];
            top1_reg <= (pk1[PKW-1:A] >= KW'(SINE_TABLE_DEPTH));
            k2_reg   <= pk2[PKW-1:A];
            r2_reg   <= pk2[A-1:0];
            top2_reg <= (pk2[PKW-1:A] >= KW'(SINE_TABLE_DEPTH));
        end
    end

    // ------------------------------------------------------------------
    // stages 2-3: sector sines
    // ------------------------------------------------------------------
    svpwm_pkg::sine_ctl_t sine_ctl;
    logic [SW-1:0] s1;
    logic [SW-1:0] s2;

    assign sine_ctl.rd_en = en[2];
    assign sine_ctl.ip_en = en[3];

    svpwm_sine_lookup #(
        .ANGLE_BITS       (ANGLE_BITS),
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_sine1 (
        .clk  (clk),
        .ctl  (sine_ctl),
        .idx  (k1_reg),
        .rem  (r1_reg),
        .top  (top1_reg),
        .sine (s1)
    );

    svpwm_sine_lookup #(
        .ANGLE_BITS       (ANGLE_BITS),
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_sine2 (
        .clk  (clk),
        .ctl  (sine_ctl),
        .idx  (k2_reg),
        .rem  (r2_reg),
        .top  (top2_reg),
        .sine (s2)
    );

    // ------------------------------------------------------------------
    // stage 4: sqrt3 scaling; stage 5: times |v|; stage 6: / 3072
    // ------------------------------------------------------------------
    logic [PW+SW-1:0]  sq1_prod;
    logic [PW+SW-1:0]  sq2_prod;
    logic [PW-1:0]     p1_reg;
    logic [PW-1:0]     p2_reg;
    logic [MW-1:0]     mag1_reg;
    logic [MW-1:0]     mag2_reg;
    logic [QW-1:0]     q1;
    logic [QW-1:0]     q2;
    logic [2*QW-1:0]   d1_prod;
    logic [2*QW-1:0]   d2_prod;
    logic [QTW-1:0]    quot1_reg;
    logic [QTW-1:0]    quot2_reg;

    assign sq1_prod = (PW+SW)'(svpwm_pkg::SQRT3_Q30) * (PW+SW)'(s1);
    assign sq2_prod = (PW+SW)'(svpwm_pkg::SQRT3_Q30) * (PW+SW)'(s2);

    // magnitudes stay below 2^43, so the quotient input fits 33 bits
    assign q1      = mag1_reg[QW+9:10];
    assign q2      = mag2_reg[QW+9:10];
    assign d1_prod = (2*QW)'(q1) * (2*QW)'(svpwm_pkg::DIV3_M);
    assign d2_prod = (2*QW)'(q2) * (2*QW)'(svpwm_pkg::DIV3_M);

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            p1_reg <= sq1_prod[PW+SW-1:30];
            p2_reg <= sq2_prod[PW+SW-1:30];
        end
        if (en[5])
        begin
            mag1_reg <= MW'(p1_reg) * MW'(vmag_reg[4]);
            mag2_reg <= MW'(p2_reg) * MW'(vmag_reg[4]);
        end
        if (en[6])
        begin
            quot1_reg <= d1_prod[svpwm_pkg::DIV3_SH+QTW-1:svpwm_pkg::DIV3_SH];
            quot2_reg <= d2_prod[svpwm_pkg::DIV3_SH+QTW-1:svpwm_pkg::DIV3_SH];
        end
    end

    // ------------------------------------------------------------------
    // stage 7: sign; stage 8: t1 + t2; stage 9: half zero time
    // ------------------------------------------------------------------
    logic signed [TW-1:0] t1_reg;
    logic signed [TW-1:0] t2_reg;
    logic signed [HW-1:0] t1b_reg;
    logic signed [HW-1:0] t2b_reg;
    logic signed [HW-1:0] t12b_reg;
    logic signed [HW-1:0] t1c_reg;
    logic signed [HW-1:0] t2c_reg;
    logic signed [HW-1:0] t12c_reg;
    logic signed [HW-1:0] h_reg;
    logic signed [HW-1:0] zdiff;
    logic signed [HW-1:0] zadj;
    logic signed [TW-1:0] t1_mag;
    logic signed [TW-1:0] t2_mag;

    assign t1_mag = $signed({1'b0, quot1_reg});
    assign t2_mag = $signed({1'b0, quot2_reg});

    // halving truncates toward zero
    assign zdiff = $signed(svpwm_pkg::ONE_Q30) - t12b_reg;
    assign zadj  = zdiff + $signed({{(HW-1){1'b0}}, zdiff[HW-1]});

    always_ff @(posedge clk)
    begin
        if (en[7])
        begin
            t1_reg <= neg_reg[6] ? -t1_mag : t1_mag;
            t2_reg <= neg_reg[6] ? -t2_mag : t2_mag;
        end
        if (en[8])
        begin
            t1b_reg  <= HW'(t1_reg);
            t2b_reg  <= HW'(t2_reg);
            t12b_reg <= HW'(t1_reg) + HW'(t2_reg);
        end
        if (en[9])
        begin
            t1c_reg  <= t1b_reg;
            t2c_reg  <= t2b_reg;
            t12c_reg <= t12b_reg;
            h_reg    <= zadj >>> 1;
        end
    end

    // ------------------------------------------------------------------
    // stage 10: sector combine; stage 11: duty rounding and saturation
    // ------------------------------------------------------------------
    logic signed [HW-1:0] xa;
    logic signed [HW-1:0] xb;
    logic signed [HW-1:0] xc;
    logic signed [HW-1:0] phase_reg [0:2];
    logic [RW-1:0]        rnd       [0:2];
    logic [DUTY_BITS-1:0] duty_next [0:2];
    logic [DUTY_BITS-1:0] duty_reg  [0:2];

    always_comb
    begin
        case (sec_reg[9])
            svpwm_pkg::SEC_0:
            begin
                xa = t12c_reg; xb = t2c_reg;  xc = '0;
            end
            svpwm_pkg::SEC_1:
            begin
                xa = t1c_reg;  xb = t12c_reg; xc = '0;
            end
            svpwm_pkg::SEC_2:
            begin
                xa = '0;       xb = t12c_reg; xc = t2c_reg;
            end
            svpwm_pkg::SEC_3:
            begin
                xa = '0;       xb = t1c_reg;  xc = t12c_reg;
            end
            svpwm_pkg::SEC_4:
            begin
                xa = t2c_reg;  xb = '0;       xc = t12c_reg;
            end
            default:
            begin
                xa = t12c_reg; xb = '0;       xc = t1c_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en[10])
        begin
            phase_reg[0] <= h_reg + xa;
            phase_reg[1] <= h_reg + xb;
            phase_reg[2] <= h_reg + xc;
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            rnd[i] = {1'b0, phase_reg[i][29:0], {DUTY_BITS{1'b0}}} + RND_HALF;
            if (phase_reg[i][HW-1] || (phase_reg[i] == '0))
            begin
                duty_next[i] = '0;
            end
            else if ((|phase_reg[i][HW-2:30]) || rnd[i][RW-1])
            begin
                duty_next[i] = DUTY_MAX;
            end
            else
            begin
                duty_next[i] = rnd[i][RW-2:30];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[11])
        begin
            for (int i = 0; i < 3; i++)
            begin
                duty_reg[i] <= duty_next[i];
            end
        end
    end

    assign duty.duty_a = 16'(duty_reg[0]);
    assign duty.duty_b = 16'(duty_reg[1]);
    assign duty.duty_c = 16'(duty_reg[2]);
    assign duty.sector = sec_reg[NST-1];

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> ($countones(vld_reg) == $past($countones(vld_reg))
                  + $past(cmd_valid && cmd_ready) - $past(duty_valid && duty_ready)))
        else $error("pipeline occupancy does not track accepted beats");

    a_bubble_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_ready && !duty_ready) |-> (vld_reg != '1))
        else $error("command taken into a full stalled pipeline");

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg == '0) |-> cmd_ready)
        else $error("empty pipeline refuses commands");

    a_sector_range: assert property (@(posedge clk) disable iff (!rst_n)
        duty_valid |-> (duty.sector <= svpwm_pkg::SEC_5))
        else $error("sector out of range");

endmodule
